@@ rtl/core/ogr_pkg.sv @@
// ----------------------------------------------------------------------------
// ogr_pkg
// Shared sizes, codes and request types of the occupancy grid ray update.
// ----------------------------------------------------------------------------
package ogr_pkg;

  localparam int GRID_WIDTH  = 1024;
  localparam int GRID_HEIGHT = 1024;

  localparam int XW    = $clog2(GRID_WIDTH);
  localparam int YW    = $clog2(GRID_HEIGHT);
  localparam int CW    = (XW > YW) ? XW : YW;
  localparam int DEPTH = GRID_WIDTH * GRID_HEIGHT;
  localparam int AW    = $clog2(DEPTH);

  localparam int SCORE_W = 7;
  localparam int COUNT_W = 12;
  localparam int STEP_W  = 4;

  localparam logic [SCORE_W-1:0] UNKNOWN_LEVEL = 7'd50;

  typedef enum logic {
    CMD_RAY  = 1'b0,
    CMD_READ = 1'b1
  } ogr_cmd_e;

  typedef enum logic [1:0] {
    STATUS_RAY_DONE = 2'd0,
    STATUS_RAY_SKIP = 2'd1,
    STATUS_READ_OK  = 2'd2,
    STATUS_READ_OFF = 2'd3
  } ogr_status_e;

  typedef struct packed {
    ogr_cmd_e           command;
    logic signed [15:0] robot_x;
    logic signed [15:0] robot_y;
    logic signed [15:0] target_x;
    logic signed [15:0] target_y;
  } ogr_in_req_t;

  typedef struct packed {
    ogr_status_e        status;
    logic [SCORE_W-1:0] cell_score;
    logic               unknown_flag;
    logic [COUNT_W-1:0] free_cells_updated;
  } ogr_out_req_t;

  typedef struct packed {
    logic          valid;
    logic          last;
    logic [XW-1:0] x;
    logic [YW-1:0] y;
  } ogr_point_t;

endpackage

@@ rtl/core/ogr_line_walker.sv @@
// ----------------------------------------------------------------------------
// ogr_line_walker
// Bresenham point generator: a difference phase and a setup phase, then one grid point per cycle.
// ----------------------------------------------------------------------------
module ogr_line_walker (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  logic [ogr_pkg::XW-1:0] robot_x_i,
  input  logic [ogr_pkg::YW-1:0] robot_y_i,
  input  logic [ogr_pkg::XW-1:0] target_x_i,
  input  logic [ogr_pkg::YW-1:0] target_y_i,
  output ogr_pkg::ogr_point_t   point_o
);
  import ogr_pkg::*;

  localparam int DW = CW + 1;
  localparam int EW = CW + 3;

  localparam logic [1:0] PH_IDLE  = 2'd0;
  localparam logic [1:0] PH_DIFF  = 2'd1;
  localparam logic [1:0] PH_SETUP = 2'd2;
  localparam logic [1:0] PH_WALK  = 2'd3;

  logic [1:0] phase_q, phase_d;

  logic [CW-1:0] rx_q, ry_q, tx_q, ty_q;
  logic signed [DW-1:0] dx_q, dy_q;
  logic [CW-1:0] a_q, a_d, b_q, b_d, a_end_q, a_end_d;
  logic [CW-1:0] dmain_q, dmain_d, dminor_q, dminor_d;
  logic signed [EW-1:0] err_q, err_d;
  logic steep_q, steep_d, step_up_q, step_up_d;

  logic [CW-1:0] adx, ady;
  logic steep, main_neg, minor_neg, minor_zero;
  logic [CW-1:0] r_main, r_minor, t_main, t_minor;
  logic signed [EW-1:0] err_n;
  logic minor_step, last;

  always_comb begin
    adx = dx_q[DW-1] ? CW'(-dx_q) : CW'(dx_q);
    ady = dy_q[DW-1] ? CW'(-dy_q) : CW'(dy_q);
    steep      = ady > adx;
    main_neg   = steep ? dy_q[DW-1] : dx_q[DW-1];
    minor_neg  = steep ? dx_q[DW-1] : dy_q[DW-1];
    minor_zero = steep ? (dx_q == '0) : (dy_q == '0);
    r_main  = steep ? ry_q : rx_q;
    r_minor = steep ? rx_q : ry_q;
    t_main  = steep ? ty_q : tx_q;
    t_minor = steep ? tx_q : ty_q;

    err_n      = err_q + $signed(EW'(dminor_q));
    minor_step = (err_n <<< 1) >= $signed(EW'(dmain_q));
    last       = a_q == a_end_q;

    phase_d   = phase_q;
    a_d       = a_q;
    b_d       = b_q;
    a_end_d   = a_end_q;
    dmain_d   = dmain_q;
    dminor_d  = dminor_q;
    err_d     = err_q;
    steep_d   = steep_q;
    step_up_d = step_up_q;

    unique case (phase_q)
      PH_IDLE: begin
        if (start_i) begin
          phase_d = PH_DIFF;
        end
      end
      PH_DIFF: begin
        phase_d = PH_SETUP;
      end
      PH_SETUP: begin
        steep_d   = steep;
        dmain_d   = steep ? ady : adx;
        dminor_d  = steep ? adx : ady;
        a_d       = main_neg ? t_main : r_main;
        b_d       = main_neg ? t_minor : r_minor;
        a_end_d   = main_neg ? r_main : t_main;
        step_up_d = main_neg ? minor_neg : (!minor_neg && !minor_zero);
        err_d     = '0;
        phase_d   = PH_WALK;
      end
      PH_WALK: begin
        a_d = a_q + CW'(1);
        if (minor_step) begin
          b_d   = step_up_q ? (b_q + CW'(1)) : (b_q - CW'(1));
          err_d = err_n - $signed(EW'(dmain_q));
        end else begin
          err_d = err_n;
        end
        if (last) begin
          phase_d = PH_IDLE;
        end
      end
      default: begin
        phase_d = PH_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
    end else begin
      phase_q <= phase_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i && phase_q == PH_IDLE) begin
      rx_q <= CW'(robot_x_i);
      ry_q <= CW'(robot_y_i);
      tx_q <= CW'(target_x_i);
      ty_q <= CW'(target_y_i);
    end
    if (phase_q == PH_DIFF) begin
      dx_q <= $signed({1'b0, tx_q}) - $signed({1'b0, rx_q});
      dy_q <= $signed({1'b0, ty_q}) - $signed({1'b0, ry_q});
    end
    a_q       <= a_d;
    b_q       <= b_d;
    a_end_q   <= a_end_d;
    dmain_q   <= dmain_d;
    dminor_q  <= dminor_d;
    err_q     <= err_d;
    steep_q   <= steep_d;
    step_up_q <= step_up_d;
  end

  assign point_o.valid = phase_q == PH_WALK;
  assign point_o.last  = last;
  assign point_o.x     = XW'(steep_q ? b_q : a_q);
  assign point_o.y     = YW'(steep_q ? a_q : b_q);

endmodule

@@ rtl/core/occupancy_grid_ray_update.sv @@
// ----------------------------------------------------------------------------
// occupancy_grid_ray_update
// Occupancy grid of 7-bit cell scores updated along Bresenham rays.
// ----------------------------------------------------------------------------
// requests enter on in_valid_i/in_ready_o (in_req_i) and results leave on
// out_valid_o/out_ready_i (out_req_o), one result per request.
// the map is one synchronous memory of GRID_WIDTH*GRID_HEIGHT scores, one
// read and one write port, with registered read data.
// after reset a clearing pass writes the unknown level into every entry, one
// entry a cycle; no request is taken before it ends, the register port
// works throughout.
// an off-grid request passes the dispatch and result states, a read passes
// dispatch, read wait and result; the result can be taken from the output
// register at the same edge at which the next request can be taken.
// a ray walks N = max(|dx|, |dy|) + 1 cells on the line: a difference and a
// setup step, then one cell per cycle through the memory read-modify-write
// (read, then write of the updated score in the next cycle), then the hit
// cell read and write; the single write port sets the one cell per cycle.
// one request is worked at a time; the result waits in an output register,
// so the next request is taken while the receiver stalls, and its result
// holds until the previous one is taken.
// registers on the APB port: 0 free_step, 1 occupied_step, 2 cell_max,
// 3 cell_min at byte addresses 0, 4, 8, 12.
module occupancy_grid_ray_update (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  ogr_pkg::ogr_in_req_t  in_req_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output ogr_pkg::ogr_out_req_t out_req_o,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [3:0]            paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready
);
  import ogr_pkg::*;

  typedef logic [AW-1:0] addr_t;

  localparam logic [1:0] REG_FREE_STEP     = 2'd0;
  localparam logic [1:0] REG_OCCUPIED_STEP = 2'd1;
  localparam logic [1:0] REG_CELL_MAX      = 2'd2;
  localparam logic [1:0] REG_CELL_MIN      = 2'd3;

  localparam logic [2:0] ST_CLEAR     = 3'd0;
  localparam logic [2:0] ST_IDLE      = 3'd1;
  localparam logic [2:0] ST_DISPATCH  = 3'd2;
  localparam logic [2:0] ST_READ_WAIT = 3'd3;
  localparam logic [2:0] ST_WALK      = 3'd4;
  localparam logic [2:0] ST_HIT_RD    = 3'd5;
  localparam logic [2:0] ST_HIT_WR    = 3'd6;
  localparam logic [2:0] ST_RESULT    = 3'd7;

  localparam addr_t LAST_ADDR = AW'(DEPTH - 1);

  function automatic addr_t cell_addr(input logic [XW-1:0] x, input logic [YW-1:0] y);
    cell_addr = AW'(x) * AW'(GRID_HEIGHT) + AW'(y);
  endfunction

  // configuration registers
  logic signed [STEP_W-1:0] free_step_q;
  logic [STEP_W-1:0]        occupied_step_q;
  logic [SCORE_W-1:0]       cell_max_q, cell_min_q;
  logic                     cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      free_step_q     <= -4'sd1;
      occupied_step_q <= 4'd2;
      cell_max_q      <= 7'd100;
      cell_min_q      <= 7'd0;
    end else if (cfg_wr) begin
      unique case (paddr[3:2])
        REG_FREE_STEP:     free_step_q     <= $signed(pwdata[STEP_W-1:0]);
        REG_OCCUPIED_STEP: occupied_step_q <= pwdata[STEP_W-1:0];
        REG_CELL_MAX:      cell_max_q      <= pwdata[SCORE_W-1:0];
        REG_CELL_MIN:      cell_min_q      <= pwdata[SCORE_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_FREE_STEP:     prdata = {28'd0, free_step_q};
      REG_OCCUPIED_STEP: prdata = {28'd0, occupied_step_q};
      REG_CELL_MAX:      prdata = {25'd0, cell_max_q};
      REG_CELL_MIN:      prdata = {25'd0, cell_min_q};
      default:           prdata = '0;
    endcase
  end

  // request capture
  logic [2:0]    state_q, state_d;
  ogr_cmd_e      cmd_q;
  logic          robot_on_q, target_on_q;
  logic [XW-1:0] rx_q, tx_q;
  logic [YW-1:0] ry_q, ty_q;
  logic          in_acc;
  logic          robot_on, target_on;

  assign in_ready_o = state_q == ST_IDLE;
  assign in_acc     = in_valid_i && in_ready_o;
  assign robot_on   = !in_req_i.robot_x[15] && !in_req_i.robot_y[15]
                      && (in_req_i.robot_x[14:0] < 15'(GRID_WIDTH))
                      && (in_req_i.robot_y[14:0] < 15'(GRID_HEIGHT));
  assign target_on  = !in_req_i.target_x[15] && !in_req_i.target_y[15]
                      && (in_req_i.target_x[14:0] < 15'(GRID_WIDTH))
                      && (in_req_i.target_y[14:0] < 15'(GRID_HEIGHT));

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      cmd_q       <= in_req_i.command;
      robot_on_q  <= robot_on;
      target_on_q <= target_on;
      rx_q        <= in_req_i.robot_x[XW-1:0];
      ry_q        <= in_req_i.robot_y[YW-1:0];
      tx_q        <= in_req_i.target_x[XW-1:0];
      ty_q        <= in_req_i.target_y[YW-1:0];
    end
  end

  // line walker
  logic       walk_start;
  ogr_point_t pt;

  ogr_line_walker u_walker (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (walk_start),
    .robot_x_i  (rx_q),
    .robot_y_i  (ry_q),
    .target_x_i (tx_q),
    .target_y_i (ty_q),
    .point_o    (pt)
  );

  // map memory
  logic [SCORE_W-1:0] map_mem [DEPTH];
  logic               rd_en, wr_en;
  addr_t              rd_addr, wr_addr, cur_addr, clr_q, clr_d;
  logic [SCORE_W-1:0] rdata_q, wr_data;

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      map_mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rdata_q <= map_mem[rd_addr];
    end
  end

  // score arithmetic
  logic signed [8:0]  free_sum;
  logic [SCORE_W-1:0] free_score;
  logic [7:0]         hit_sum;
  logic [SCORE_W-1:0] hit_score;

  always_comb begin
    free_sum = $signed({2'b00, rdata_q}) + $signed({{5{free_step_q[STEP_W-1]}}, free_step_q});
    if (free_sum < $signed({2'b00, cell_min_q})) begin
      free_score = cell_min_q;
    end else if (free_sum > 9'sd127) begin
      free_score = 7'd127;
    end else begin
      free_score = free_sum[SCORE_W-1:0];
    end
    hit_sum   = {1'b0, rdata_q} + {4'd0, occupied_step_q};
    hit_score = (hit_sum > {1'b0, cell_max_q}) ? cell_max_q : hit_sum[SCORE_W-1:0];
  end

  // sequencer
  logic               fw_valid_q, fw_valid_d;
  addr_t              fw_addr_q;
  logic [COUNT_W-1:0] count_q, count_d;
  ogr_out_req_t       res_q, res_d;
  logic               res_load, res_send;
  logic               pt_hit;
  ogr_out_req_t       out_q;
  logic               out_valid_q;

  assign cur_addr = (state_q == ST_WALK) ? cell_addr(pt.x, pt.y) : cell_addr(tx_q, ty_q);
  assign pt_hit   = (pt.x == tx_q) && (pt.y == ty_q);
  assign res_send = (state_q == ST_RESULT) && (!out_valid_q || out_ready_i);

  always_comb begin
    state_d    = state_q;
    clr_d      = clr_q;
    count_d    = count_q;
    walk_start = 1'b0;
    rd_en      = 1'b0;
    rd_addr    = cur_addr;
    fw_valid_d = 1'b0;
    res_load   = 1'b0;
    res_d      = '0;

    unique case (state_q)
      ST_CLEAR: begin
        clr_d = clr_q + AW'(1);
        if (clr_q == LAST_ADDR) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_acc) begin
          state_d = ST_DISPATCH;
        end
      end
      ST_DISPATCH: begin
        if (cmd_q == CMD_READ) begin
          if (target_on_q) begin
            rd_en   = 1'b1;
            state_d = ST_READ_WAIT;
          end else begin
            res_load     = 1'b1;
            res_d.status = STATUS_READ_OFF;
            state_d      = ST_RESULT;
          end
        end else begin
          if (robot_on_q && target_on_q) begin
            walk_start = 1'b1;
            count_d    = '0;
            state_d    = ST_WALK;
          end else begin
            res_load     = 1'b1;
            res_d.status = STATUS_RAY_SKIP;
            state_d      = ST_RESULT;
          end
        end
      end
      ST_READ_WAIT: begin
        res_load           = 1'b1;
        res_d.status       = STATUS_READ_OK;
        res_d.cell_score   = rdata_q;
        res_d.unknown_flag = rdata_q == UNKNOWN_LEVEL;
        state_d            = ST_RESULT;
      end
      ST_WALK: begin
        if (pt.valid) begin
          if (!pt_hit) begin
            rd_en      = 1'b1;
            fw_valid_d = 1'b1;
            if (count_q != '1) begin
              count_d = count_q + COUNT_W'(1);
            end
          end
          if (pt.last) begin
            state_d = ST_HIT_RD;
          end
        end
      end
      ST_HIT_RD: begin
        rd_en   = 1'b1;
        state_d = ST_HIT_WR;
      end
      ST_HIT_WR: begin
        res_load                 = 1'b1;
        res_d.status             = STATUS_RAY_DONE;
        res_d.cell_score         = hit_score;
        res_d.unknown_flag       = hit_score == UNKNOWN_LEVEL;
        res_d.free_cells_updated = count_q;
        state_d                  = ST_RESULT;
      end
      ST_RESULT: begin
        if (res_send) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // write port: clearing pass, free cell write-back, hit cell write-back
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = cur_addr;
    wr_data = hit_score;
    priority if (state_q == ST_CLEAR) begin
      wr_en   = 1'b1;
      wr_addr = clr_q;
      wr_data = UNKNOWN_LEVEL;
    end else if (fw_valid_q) begin
      wr_en   = 1'b1;
      wr_addr = fw_addr_q;
      wr_data = free_score;
    end else if (state_q == ST_HIT_WR) begin
      wr_en = 1'b1;
    end else begin
      wr_en = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_q       <= '0;
      fw_valid_q  <= 1'b0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      clr_q      <= clr_d;
      fw_valid_q <= fw_valid_d;
      count_q    <= count_d;
      if (res_send) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    fw_addr_q <= cur_addr;
    if (res_load) begin
      res_q <= res_d;
    end
    if (res_send) begin
      out_q <= res_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_req_o   = out_q;

endmodule

@@ rtl/core/ogr_checker.sv @@
// ----------------------------------------------------------------------------
// ogr_checker
// Port-level checks of the occupancy grid ray update, bound to the top level.
// ----------------------------------------------------------------------------
module ogr_checker (
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  in_valid_i,
  input logic                  in_ready_o,
  input logic                  out_valid_o,
  input logic                  out_ready_i,
  input ogr_pkg::ogr_out_req_t out_req_o
);
  import ogr_pkg::*;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_req_o))
    else $error("result dropped or changed while stalled");

  a_unknown_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_req_o.unknown_flag == (out_req_o.cell_score == UNKNOWN_LEVEL))
    else $error("unknown flag does not match cell score");

  a_count_ray_only: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_req_o.status != STATUS_RAY_DONE
      |-> out_req_o.free_cells_updated == '0)
    else $error("free cell count on a result without a ray");

  a_off_grid_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_req_o.status == STATUS_RAY_SKIP
                    || out_req_o.status == STATUS_READ_OFF)
      |-> out_req_o.cell_score == '0 && !out_req_o.unknown_flag)
    else $error("off grid result carries a score");

  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("request taken while previous request in work");

endmodule

bind occupancy_grid_ray_update ogr_checker u_ogr_checker (.*);
